// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define SMS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define SMS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/sms_pkg.sv =====
// ----------------------------------------------------------------------------
// sms_pkg
// Types, constants and helpers of the smoothstep servo motion profiler.
// ----------------------------------------------------------------------------
package sms_pkg;

  localparam int unsigned AngleW    = 17;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned FracW     = 16;
  localparam int unsigned OutAngleW = 15;
  localparam int unsigned PulseW    = 12;
  localparam int unsigned SumW      = 20;
  localparam int unsigned AngleMax  = 18000;
  localparam int unsigned PulseBase = 500;
  localparam int unsigned ThreeQ16  = 3 * 65536;
  // floor(a/9) = (a * Div9Mul) >> Div9Shift, exact for a < 2^17
  localparam int unsigned Div9Mul   = 116509;
  localparam int unsigned Div9Shift = 20;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_SET   = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CHECK,
    ST_DIV,
    ST_MUL_SQ,
    ST_MUL_H,
    ST_MUL_P,
    ST_BLEND,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load_item;
    logic store_motion;
    logic clr_idx;
    logic clr_all;
    logic rec_direct;
    logic rec_final;
    logic rec_smooth;
    logic div_init;
    logic div_step;
    logic mul_sq;
    logic mul_h;
    logic mul_p;
    logic walk_clr;
    logic walk_inc;
    logic emit_load;
  } cmd_t;

  typedef struct packed {
    op_e  opcode;
    logic idx_ok;
    logic dur_zero;
    logic act_w;
    logic done_w;
    logic w_last;
    logic div_last;
    logic res_w;
    logic res_any;
    logic out_free;
  } sts_t;

  function automatic logic [OutAngleW-1:0] clamp_angle(input logic signed [SumW-1:0] a);
    logic [OutAngleW-1:0] r;
    if (a < 0) begin
      r = '0;
    end else if (a > SumW'(AngleMax)) begin
      r = OutAngleW'(AngleMax);
    end else begin
      r = a[OutAngleW-1:0];
    end
    return r;
  endfunction

  function automatic logic [PulseW-1:0] angle_to_pulse(input logic [OutAngleW-1:0] a);
    logic [31:0] prod;
    prod = 32'(a) * 32'(Div9Mul);
    return PulseW'(PulseBase) + prod[Div9Shift +: PulseW];
  endfunction

endpackage

// ===== hw/rtl/sms_ctrl.sv =====
// ----------------------------------------------------------------------------
// sms_ctrl
// Sequencer: decodes an item, walks the servos, drives the datapath.
// ----------------------------------------------------------------------------
module sms_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sms_pkg::sts_t sts_i,
  output sms_pkg::cmd_t cmd_o,
  output logic          busy_o
);

  sms_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sms_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sms_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = sms_pkg::ST_DECODE;
      end
      sms_pkg::ST_DECODE: begin
        unique case (sts_i.opcode)
          sms_pkg::OP_TICK:  state_d = sms_pkg::ST_CHECK;
          sms_pkg::OP_START: state_d = (sts_i.idx_ok && sts_i.dur_zero) ?
                                       sms_pkg::ST_EMIT : sms_pkg::ST_IDLE;
          sms_pkg::OP_SET:   state_d = sts_i.idx_ok ? sms_pkg::ST_EMIT : sms_pkg::ST_IDLE;
          default:           state_d = sms_pkg::ST_IDLE;
        endcase
      end
      sms_pkg::ST_CHECK: begin
        if (sts_i.act_w && !sts_i.done_w) begin
          state_d = sms_pkg::ST_DIV;
        end else begin
          state_d = sts_i.w_last ? sms_pkg::ST_EMIT : sms_pkg::ST_CHECK;
        end
      end
      sms_pkg::ST_DIV: begin
        if (sts_i.div_last) state_d = sms_pkg::ST_MUL_SQ;
      end
      sms_pkg::ST_MUL_SQ: state_d = sms_pkg::ST_MUL_H;
      sms_pkg::ST_MUL_H:  state_d = sms_pkg::ST_MUL_P;
      sms_pkg::ST_MUL_P:  state_d = sms_pkg::ST_BLEND;
      sms_pkg::ST_BLEND: begin
        state_d = sts_i.w_last ? sms_pkg::ST_EMIT : sms_pkg::ST_CHECK;
      end
      sms_pkg::ST_EMIT: begin
        if (sts_i.w_last && (!sts_i.res_w || sts_i.out_free)) state_d = sms_pkg::ST_IDLE;
      end
      default: state_d = sms_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      sms_pkg::ST_IDLE: begin
        in_ready_o       = 1'b1;
        cmd_o.load_item  = in_valid_i;
        cmd_o.walk_clr   = in_valid_i;
      end
      sms_pkg::ST_DECODE: begin
        unique case (sts_i.opcode)
          sms_pkg::OP_START: begin
            if (sts_i.idx_ok) begin
              if (sts_i.dur_zero) begin
                cmd_o.rec_direct = 1'b1;
                cmd_o.clr_idx    = 1'b1;
              end else begin
                cmd_o.store_motion = 1'b1;
              end
            end
          end
          sms_pkg::OP_STOP: cmd_o.clr_all = 1'b1;
          sms_pkg::OP_SET:  cmd_o.rec_direct = sts_i.idx_ok;
          default: ;
        endcase
      end
      sms_pkg::ST_CHECK: begin
        if (sts_i.act_w && !sts_i.done_w) begin
          cmd_o.div_init = 1'b1;
        end else begin
          cmd_o.rec_final = sts_i.act_w;
          cmd_o.walk_clr  = sts_i.w_last;
          cmd_o.walk_inc  = !sts_i.w_last;
        end
      end
      sms_pkg::ST_DIV:    cmd_o.div_step = 1'b1;
      sms_pkg::ST_MUL_SQ: cmd_o.mul_sq = 1'b1;
      sms_pkg::ST_MUL_H:  cmd_o.mul_h = 1'b1;
      sms_pkg::ST_MUL_P:  cmd_o.mul_p = 1'b1;
      sms_pkg::ST_BLEND: begin
        cmd_o.rec_smooth = 1'b1;
        cmd_o.walk_clr   = sts_i.w_last;
        cmd_o.walk_inc   = !sts_i.w_last;
      end
      sms_pkg::ST_EMIT: begin
        // hold on a pending result until the output register frees up
        if (!sts_i.res_w || sts_i.out_free) begin
          cmd_o.emit_load = sts_i.res_w;
          cmd_o.walk_inc  = !sts_i.w_last;
        end
      end
      default: ;
    endcase
  end

  assign busy_o = (state_q != sms_pkg::ST_IDLE);

endmodule

// ===== hw/rtl/sms_dp.sv =====
// ----------------------------------------------------------------------------
// sms_dp
// Servo state, Q16 divider, smoothstep multiplies, result buffer, output reg.
// ----------------------------------------------------------------------------
module sms_dp #(
  parameter int unsigned NumServos = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [1:0]    opcode_i,
  input  logic [1:0]    servo_index_i,
  input  logic signed [sms_pkg::AngleW-1:0] src_angle_i,
  input  logic signed [sms_pkg::AngleW-1:0] dst_angle_i,
  input  logic [sms_pkg::TimeW-1:0] duration_i,
  input  logic [sms_pkg::TimeW-1:0] time_now_i,
  input  sms_pkg::cmd_t cmd_i,
  output sms_pkg::sts_t sts_o,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output logic          servo_out_o,
  output logic [sms_pkg::PulseW-1:0]    pulse_compare_o,
  output logic [sms_pkg::OutAngleW-1:0] angle_out_o,
  output logic [1:0]    moving_mask_o,
  output logic          last_result_o
);

  localparam int unsigned IdxW = (NumServos > 1) ? $clog2(NumServos) : 1;
  localparam int unsigned AW   = sms_pkg::AngleW;
  localparam int unsigned TW   = sms_pkg::TimeW;
  localparam int unsigned FW   = sms_pkg::FracW;
  localparam int unsigned OW   = sms_pkg::OutAngleW;
  localparam int unsigned SW   = sms_pkg::SumW;
  localparam int unsigned PW   = AW + 1 + FW + 1;  // signed diff * unsigned h

  // latched item
  sms_pkg::op_e            op_q;
  logic [1:0]              idx_q;
  logic signed [AW-1:0]    a0_q, a1_q;
  logic [TW-1:0]           dur_q, now_q;

  // per-servo motion state
  logic [NumServos-1:0]    active_q;
  logic signed [AW-1:0]    from_q  [NumServos];
  logic signed [AW-1:0]    to_q    [NumServos];
  logic [TW-1:0]           len_q   [NumServos];
  logic [TW-1:0]           begin_q [NumServos];

  // result buffer, one slot per servo
  logic [NumServos-1:0]    res_valid_q;
  logic [OW-1:0]           res_angle_q [NumServos];

  logic [IdxW-1:0]         w_q;
  logic [3:0]              div_cnt_q;
  logic [TW-1:0]           rem_q;
  logic [FW-1:0]           s_q;
  logic [2*FW-1:0]         sq_q;
  logic [FW-1:0]           h_q;
  logic signed [PW-1:0]    p_q;

  logic                    out_valid_q;
  logic                    servo_q, last_q;
  logic [sms_pkg::PulseW-1:0] pulse_q;
  logic [OW-1:0]           angle_q;
  logic [1:0]              mask_q;

  logic [IdxW-1:0]         idx_w;
  logic [TW-1:0]           elapsed;
  logic [TW:0]             rem2;
  logic                    q_bit;
  logic [FW+1:0]           cubic_k;
  logic [2*FW+FW+2-1:0]    h_prod;
  logic signed [AW:0]      diff;
  logic signed [SW-1:0]    blend;
  logic [3:0]              act_pad;
  logic                    more;
  logic                    out_free;

  assign idx_w   = idx_q[IdxW-1:0];
  assign elapsed = now_q - begin_q[w_q];
  assign rem2    = {rem_q, 1'b0};
  assign q_bit   = (rem2 >= {1'b0, len_q[w_q]});
  assign cubic_k = (FW+2)'(sms_pkg::ThreeQ16) - {1'b0, s_q, 1'b0};
  assign h_prod  = (3*FW+2)'(sq_q) * (3*FW+2)'(cubic_k);
  assign diff    = (AW+1)'(to_q[w_q]) - (AW+1)'(from_q[w_q]);
  // arithmetic shift of the product floors toward minus infinity
  assign blend   = SW'(from_q[w_q]) + SW'($signed(p_q[PW-1:FW]));
  assign act_pad = 4'(active_q);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    more = 1'b0;
    for (int i = 0; i < NumServos; i++) begin
      if ((IdxW'(i) > w_q) && res_valid_q[i]) more = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q  <= sms_pkg::op_e'(opcode_i);
      idx_q <= servo_index_i;
      a0_q  <= src_angle_i;
      a1_q  <= dst_angle_i;
      dur_q <= duration_i;
      now_q <= time_now_i;
    end
    if (cmd_i.store_motion) begin
      from_q[idx_w]  <= a0_q;
      to_q[idx_w]    <= a1_q;
      len_q[idx_w]   <= dur_q;
      begin_q[idx_w] <= now_q;
    end
    if (cmd_i.rec_direct) res_angle_q[idx_w] <= sms_pkg::clamp_angle(SW'(a1_q));
    if (cmd_i.rec_final)  res_angle_q[w_q]   <= sms_pkg::clamp_angle(SW'(to_q[w_q]));
    if (cmd_i.rec_smooth) res_angle_q[w_q]   <= sms_pkg::clamp_angle(blend);
    if (cmd_i.div_init) begin
      rem_q <= elapsed;
      s_q   <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= q_bit ? TW'(rem2 - {1'b0, len_q[w_q]}) : rem_q << 1;
      s_q   <= {s_q[FW-2:0], q_bit};
    end
    if (cmd_i.mul_sq) sq_q <= (2*FW)'(s_q) * (2*FW)'(s_q);
    if (cmd_i.mul_h)  h_q  <= h_prod[2*FW +: FW];
    if (cmd_i.mul_p)  p_q  <= PW'(diff) * $signed(PW'({1'b0, h_q}));
    if (cmd_i.emit_load) begin
      servo_q <= w_q[0];
      angle_q <= res_angle_q[w_q];
      pulse_q <= sms_pkg::angle_to_pulse(res_angle_q[w_q]);
      mask_q  <= act_pad[1:0];
      last_q  <= !more;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= '0;
      res_valid_q <= '0;
      w_q         <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_all)      active_q        <= '0;
      if (cmd_i.clr_idx)      active_q[idx_w] <= 1'b0;
      if (cmd_i.store_motion) active_q[idx_w] <= 1'b1;
      if (cmd_i.rec_final)    active_q[w_q]   <= 1'b0;
      if (cmd_i.rec_direct)   res_valid_q[idx_w] <= 1'b1;
      if (cmd_i.rec_final || cmd_i.rec_smooth) res_valid_q[w_q] <= 1'b1;
      if (cmd_i.emit_load)    res_valid_q[w_q] <= 1'b0;
      if (cmd_i.walk_clr) begin
        w_q <= '0;
      end else if (cmd_i.walk_inc) begin
        w_q <= w_q + 1'b1;
      end
      if (cmd_i.div_init) begin
        div_cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + 1'b1;
      end
      if (cmd_i.emit_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o          = '0;
    sts_o.opcode   = op_q;
    sts_o.idx_ok   = (32'(idx_q) < NumServos);
    sts_o.dur_zero = (dur_q == '0);
    sts_o.act_w    = active_q[w_q];
    sts_o.done_w   = (elapsed >= len_q[w_q]);
    sts_o.w_last   = (w_q == IdxW'(NumServos - 1));
    sts_o.div_last = (div_cnt_q == 4'(FW - 1));
    sts_o.res_w    = res_valid_q[w_q];
    sts_o.res_any  = |res_valid_q;
    sts_o.out_free = out_free;
  end

  assign out_valid_o     = out_valid_q;
  assign servo_out_o     = servo_q;
  assign pulse_compare_o = pulse_q;
  assign angle_out_o     = angle_q;
  assign moving_mask_o   = mask_q;
  assign last_result_o   = last_q;

endmodule

// ===== hw/rtl/servo_smoothstep_motion_profiler.sv =====
// ----------------------------------------------------------------------------
// servo_smoothstep_motion_profiler
// Cubic smoothstep servo trajectories turned into PWM compare values.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis): one command per transfer, opcode in tuser.
//   Tick walks every active servo and emits one result per active servo;
//   start with zero duration and set emit one result; stop emits nothing.
//   Output stream (m_axis): one result per transfer, tlast on the final
//   result of a command, servo number in tuser.
//   Sequencing: one command at a time. After decode, a tick checks each servo
//   in turn and runs each servo still in motion through a restoring Q16
//   divider, the square, cubic and product multiplies and a blend, then
//   drains the result buffer one servo at a time.
//   A single output register sits between the result buffer and m_axis; a
//   stalled receiver holds the drain, and s_axis_tready stays low until all
//   results of the current command have been moved into the output register.
//   Reset clears all motion flags and the output valid; stored trajectory
//   data is undefined until a start command writes it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module servo_smoothstep_motion_profiler #(
  parameter int unsigned NUM_SERVOS = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [1:0] servo_index, [18:2] src_angle, [35:19] dst_angle,
  // [67:36] duration, [99:68] time_now, [103:100] zero
  input  logic [103:0] s_axis_tdata,
  // [1:0] opcode
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [11:0] pulse_compare, [26:12] angle_out, [28:27] moving_mask, [31:29] zero
  output logic [31:0]  m_axis_tdata,
  // [0] servo_out
  output logic [0:0]   m_axis_tuser,
  output logic         m_axis_tlast
);

  sms_pkg::cmd_t cmd;
  sms_pkg::sts_t sts;
  logic          busy;
  logic [sms_pkg::PulseW-1:0]    pulse;
  logic [sms_pkg::OutAngleW-1:0] angle;
  logic [1:0]    mask;

  sms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  sms_dp #(
    .NumServos (NUM_SERVOS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .opcode_i        (s_axis_tuser),
    .servo_index_i   (s_axis_tdata[1:0]),
    .src_angle_i     (s_axis_tdata[18:2]),
    .dst_angle_i     (s_axis_tdata[35:19]),
    .duration_i      (s_axis_tdata[67:36]),
    .time_now_i      (s_axis_tdata[99:68]),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .servo_out_o     (m_axis_tuser[0]),
    .pulse_compare_o (pulse),
    .angle_out_o     (angle),
    .moving_mask_o   (mask),
    .last_result_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, mask, angle, pulse};

  `SMS_ASSERT(a_one_cmd_at_a_time, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "input taken while busy")
  `SMS_ASSERT(a_results_drain_first, clk_i, rst_ni, sts.res_any |-> (busy && !s_axis_tready), "results pending while idle")
  `SMS_ASSERT_ALWAYS(a_reset_no_output, clk_i, !rst_ni |=> !m_axis_tvalid, "output valid after reset")

endmodule
